// ----- hw/rtl/stt_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// stt_pkg: shared types, constants and helper functions for the tokenizer
// Holds the source and token word layouts, the lexer modes, the token kind
// codes and the character class / lookup functions used by the lexer core.
// ----------------------------------------------------------------------------
package stt_pkg;

    // position and length widths
    localparam int POS_BITS  = 16;
    localparam int LEN_BITS  = 12;
    localparam int KIND_BITS = 5;

    localparam logic [POS_BITS-1:0] POS_MAX = '1;
    localparam logic [LEN_BITS-1:0] LEN_MAX = '1;

    // special bytes
    localparam logic [7:0] CH_NEWLINE    = 8'h0A;
    localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CH_QUOTE      = 8'h22;
    localparam logic [7:0] CH_BACKSLASH  = 8'h5C;
    localparam logic [7:0] COMMENT_RESET = 8'h23;

    // source word kinds
    localparam logic ITEM_BYTE = 1'b0;
    localparam logic ITEM_END  = 1'b1;

    // token kind codes
    localparam logic [KIND_BITS-1:0] TK_END        = 5'd0;
    localparam logic [KIND_BITS-1:0] TK_WORD       = 5'd1;
    localparam logic [KIND_BITS-1:0] TK_PUNCT_BASE = 5'd2;
    localparam logic [KIND_BITS-1:0] TK_KW_BASE    = 5'd18;
    localparam logic [KIND_BITS-1:0] TK_NUMBER     = 5'd23;
    localparam logic [KIND_BITS-1:0] TK_STRING     = 5'd24;
    localparam logic [KIND_BITS-1:0] TK_UNCLOSED   = 5'd25;
    localparam logic [KIND_BITS-1:0] TK_UNKNOWN    = 5'd26;

    // keywords
    localparam int KW_ID_BITS  = 3;
    localparam int KW_POS_BITS = 3;
    localparam logic [KW_ID_BITS-1:0] KW_LET    = 3'd0;
    localparam logic [KW_ID_BITS-1:0] KW_PROC   = 3'd1;
    localparam logic [KW_ID_BITS-1:0] KW_IF     = 3'd2;
    localparam logic [KW_ID_BITS-1:0] KW_WHILE  = 3'd3;
    localparam logic [KW_ID_BITS-1:0] KW_RETURN = 3'd4;

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_COMMENT,
        MODE_WORD,
        MODE_NUMBER,
        MODE_STRING
    } lex_mode_t;

    typedef struct packed {
        logic       kind;
        logic [7:0] text_byte;
    } src_item_t;

    typedef struct packed {
        logic [KIND_BITS-1:0] token_kind;
        logic [POS_BITS-1:0]  start_row;
        logic [POS_BITS-1:0]  start_col;
        logic [LEN_BITS-1:0]  token_length;
        logic                 last_of_run;
    } tok_item_t;

    // results of one source word, first one in order first
    typedef struct packed {
        logic [1:0] cnt;
        tok_item_t  first;
        tok_item_t  second;
    } tok_pair_t;

    typedef struct packed {
        logic       hit;
        logic [3:0] idx;
    } punct_sel_t;

    typedef struct packed {
        logic                  hit;
        logic [KW_ID_BITS-1:0] id;
    } kw_sel_t;

    function automatic logic [POS_BITS-1:0] sat_pos(input logic [POS_BITS-1:0] v);
        return (v == POS_MAX) ? v : v + POS_BITS'(1);
    endfunction

    function automatic logic [LEN_BITS-1:0] sat_len(input logic [LEN_BITS-1:0] v);
        return (v == LEN_MAX) ? v : v + LEN_BITS'(1);
    endfunction

    function automatic logic is_space(input logic [7:0] b);
        return (b == 8'h20) || ((b >= 8'h09) && (b <= 8'h0D));
    endfunction

    function automatic logic is_alpha(input logic [7:0] b);
        return ((b >= 8'h41) && (b <= 8'h5A)) || ((b >= 8'h61) && (b <= 8'h7A));
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return (b >= 8'h30) && (b <= 8'h39);
    endfunction

    function automatic tok_item_t make_tok(input logic [KIND_BITS-1:0] kind,
                                           input logic [POS_BITS-1:0]  row,
                                           input logic [POS_BITS-1:0]  col,
                                           input logic [LEN_BITS-1:0]  len);
        tok_item_t t;
        t.token_kind   = kind;
        t.start_row    = row;
        t.start_col    = col;
        t.token_length = len;
        t.last_of_run  = 1'b0;
        return t;
    endfunction

    // one-character punctuators in kind order
    function automatic punct_sel_t punct_lookup(input logic [7:0] b);
        punct_sel_t s;
        s.hit = 1'b1;
        case (b)
            "(":     s.idx = 4'd0;
            ")":     s.idx = 4'd1;
            "{":     s.idx = 4'd2;
            "}":     s.idx = 4'd3;
            "[":     s.idx = 4'd4;
            "]":     s.idx = 4'd5;
            ";":     s.idx = 4'd6;
            ":":     s.idx = 4'd7;
            "^":     s.idx = 4'd8;
            "=":     s.idx = 4'd9;
            "+":     s.idx = 4'd10;
            "-":     s.idx = 4'd11;
            "*":     s.idx = 4'd12;
            "/":     s.idx = 4'd13;
            ",":     s.idx = 4'd14;
            "<":     s.idx = 4'd15;
            default:
            begin
                s.hit = 1'b0;
                s.idx = 4'd0;
            end
        endcase
        return s;
    endfunction

    // keyword whose first letter is b
    function automatic kw_sel_t kw_first(input logic [7:0] b);
        kw_sel_t s;
        s.hit = 1'b1;
        case (b)
            "l":     s.id = KW_LET;
            "p":     s.id = KW_PROC;
            "i":     s.id = KW_IF;
            "w":     s.id = KW_WHILE;
            "r":     s.id = KW_RETURN;
            default:
            begin
                s.hit = 1'b0;
                s.id  = KW_LET;
            end
        endcase
        return s;
    endfunction

    function automatic logic [KW_POS_BITS-1:0] kw_len(input logic [KW_ID_BITS-1:0] id);
        case (id)
            KW_LET:    return 3'd3;
            KW_PROC:   return 3'd4;
            KW_IF:     return 3'd2;
            KW_WHILE:  return 3'd5;
            KW_RETURN: return 3'd6;
            default:   return 3'd0;
        endcase
    endfunction

    function automatic logic [7:0] kw_char(input logic [KW_ID_BITS-1:0]  id,
                                           input logic [KW_POS_BITS-1:0] pos);
        logic [47:0] txt;
        case (id)
            KW_LET:    txt = {"let",    24'h0};
            KW_PROC:   txt = {"proc",   16'h0};
            KW_IF:     txt = {"if",     32'h0};
            KW_WHILE:  txt = {"while",  8'h0};
            KW_RETURN: txt = "return";
            default:   txt = 48'h0;
        endcase
        case (pos)
            3'd0:    return txt[47:40];
            3'd1:    return txt[39:32];
            3'd2:    return txt[31:24];
            3'd3:    return txt[23:16];
            3'd4:    return txt[15:8];
            3'd5:    return txt[7:0];
            default: return 8'h00;
        endcase
    endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/source_text_tokenizer.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// source_text_tokenizer: streaming lexer for source text
// Source words (one byte or an end-of-text mark) enter on the src channel;
// token words leave on the tok channel. The comment byte is written on the
// cfg channel.
//
// Usage:
//   src channel: src_valid / src_stall / src_word. One byte per cycle is
//   taken into an input register while src_stall is low. A byte is lexed
//   once the four-entry queue has room, and its tokens are written there.
//   tok channel: tok_valid / tok_stall / tok_word. The queue offers one
//   token word per cycle while tok_stall is low; a token is registered in
//   the queue when its byte is lexed and is offered from there on the port.
//   Throughput is one byte per cycle while src_stall is low. Two tokens of
//   one byte leave in turn on the single token port; src_stall rises while
//   the queue has fewer than two free entries and a byte is waiting to be
//   lexed. When tok_stall is high, the queue fills and then src_stall holds.
//   cfg channel: cfg_valid / cfg_ready / cfg_data, always ready; write only
//   while no bytes are in flight.
//   Reset: empties the queue, sets the lexer idle at line 1, column 1 and
//   the comment byte to '#'.
// ----------------------------------------------------------------------------
module source_text_tokenizer (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               src_valid,
    output logic                    src_stall,
    input  wire stt_pkg::src_item_t src_word,
    output logic                    tok_valid,
    input  wire logic               tok_stall,
    output stt_pkg::tok_item_t      tok_word,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [7:0]         cfg_data
);
    import stt_pkg::*;

    logic       src_vld_reg, src_vld_next;
    src_item_t  src_item_reg;
    logic       src_accept;
    logic       step;
    logic       room;
    logic       pop;
    tok_pair_t  pair;

    // input register handshake
    assign step       = src_vld_reg && room;
    assign src_stall  = src_vld_reg && !room;
    assign src_accept = src_valid && !src_stall;
    assign src_vld_next = src_accept ? 1'b1 : (step ? 1'b0 : src_vld_reg);

    assign cfg_ready = 1'b1;
    assign pop       = tok_valid && !tok_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_vld_reg <= 1'b0;
        end
        else
        begin
            src_vld_reg <= src_vld_next;
        end
    end

    // source word payload
    always_ff @(posedge clk)
    begin
        if (src_accept)
        begin
            src_item_reg <= src_word;
        end
    end

    // lexer core
    stt_lex_core u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (step),
        .item     (src_item_reg),
        .cfg_we   (cfg_valid && cfg_ready),
        .cfg_data (cfg_data),
        .pair     (pair)
    );

    // token queue
    stt_tok_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (step),
        .pair      (pair),
        .pop       (pop),
        .head      (tok_word),
        .not_empty (tok_valid),
        .room_two  (room)
    );

    // end of text always yields at least the end token
    assert property (@(posedge clk) disable iff (!rst_n)
        (step && (src_item_reg.kind == ITEM_END)) |-> (pair.cnt != 2'd0))
        else $error("end of text produced no token");

    // at most two tokens per byte
    assert property (@(posedge clk) disable iff (!rst_n)
        step |-> (pair.cnt != 2'd3))
        else $error("lexer produced more than two tokens");

    // with two tokens only the second closes the run
    assert property (@(posedge clk) disable iff (!rst_n)
        (step && (pair.cnt == 2'd2)) |->
            (!pair.first.last_of_run && pair.second.last_of_run))
        else $error("last_of_run misplaced on token pair");

    // queue only drains through a taken token
    assert property (@(posedge clk) disable iff (!rst_n)
        $fell(tok_valid) |-> $past(tok_valid && !tok_stall))
        else $error("token queue emptied without a pop");

endmodule
`default_nettype wire

// ----- hw/rtl/stt_lex_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// stt_lex_core: lexer state and single-pass token decision
// Holds the lexer mode, keyword progress, position counters and the comment
// byte register; works out up to two tokens for one source word per step cycle.
// ----------------------------------------------------------------------------
module stt_lex_core (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             step,
    input  wire stt_pkg::src_item_t item,
    input  wire logic             cfg_we,
    input  wire logic [7:0]       cfg_data,
    output stt_pkg::tok_pair_t    pair
);
    import stt_pkg::*;

    lex_mode_t                mode_reg, mode_next;
    logic [KW_ID_BITS-1:0]    kw_id_reg, kw_id_next;
    logic [KW_POS_BITS-1:0]   kw_pos_reg, kw_pos_next;
    logic                     esc_reg, esc_next;
    logic [POS_BITS-1:0]      line_reg, line_next;
    logic [POS_BITS-1:0]      col_reg, col_next;
    logic [POS_BITS-1:0]      tok_row_reg, tok_row_next;
    logic [POS_BITS-1:0]      tok_col_reg, tok_col_next;
    logic [LEN_BITS-1:0]      len_reg, len_next;
    logic [7:0]               comment_char_reg;

    logic [7:0]               b;
    logic [POS_BITS-1:0]      row_cur;
    logic [POS_BITS-1:0]      col_cur;
    logic [LEN_BITS-1:0]      len_inc;
    punct_sel_t               punct;
    kw_sel_t                  kw_sel;
    logic                     kw_match;

    // token start outcome
    lex_mode_t                bt_mode;
    logic [KW_ID_BITS-1:0]    bt_kw_id;
    logic [KW_POS_BITS-1:0]   bt_kw_pos;
    logic [LEN_BITS-1:0]      bt_len;
    logic                     bt_emit;
    logic [KIND_BITS-1:0]     bt_kind;

    logic                     use_bt;
    logic                     e1_vld, e2_vld;
    tok_item_t                e1, e2;

    assign b       = item.text_byte;
    assign row_cur = sat_pos(line_reg);
    assign col_cur = sat_pos(col_reg);
    assign len_inc = sat_len(len_reg);
    assign punct   = punct_lookup(b);
    assign kw_sel  = kw_first(b);
    assign kw_match = (kw_pos_reg != '0) && (kw_pos_reg < kw_len(kw_id_reg))
                      && (kw_char(kw_id_reg, kw_pos_reg) == b);

    // classify a byte that starts a token
    always_comb
    begin
        bt_mode   = MODE_IDLE;
        bt_kw_id  = KW_LET;
        bt_kw_pos = '0;
        bt_len    = '0;
        bt_emit   = 1'b0;
        bt_kind   = TK_UNKNOWN;
        if (is_space(b))
        begin
            bt_mode = MODE_IDLE;
        end
        else if (b == comment_char_reg)
        begin
            bt_mode = MODE_COMMENT;
        end
        else if (punct.hit)
        begin
            bt_emit = 1'b1;
            bt_kind = TK_PUNCT_BASE + {1'b0, punct.idx};
        end
        else if (b == CH_QUOTE)
        begin
            bt_mode = MODE_STRING;
        end
        else if (is_alpha(b) || (b == CH_UNDERSCORE))
        begin
            bt_mode = MODE_WORD;
            bt_len  = LEN_BITS'(1);
            if (kw_sel.hit)
            begin
                bt_kw_id  = kw_sel.id;
                bt_kw_pos = KW_POS_BITS'(1);
            end
        end
        else if (is_digit(b))
        begin
            bt_mode = MODE_NUMBER;
            bt_len  = LEN_BITS'(1);
        end
        else
        begin
            bt_emit = 1'b1;
            bt_kind = TK_UNKNOWN;
        end
    end

    // next state and emitted tokens
    always_comb
    begin
        mode_next    = mode_reg;
        kw_id_next   = kw_id_reg;
        kw_pos_next  = kw_pos_reg;
        esc_next     = esc_reg;
        line_next    = line_reg;
        col_next     = col_reg;
        tok_row_next = tok_row_reg;
        tok_col_next = tok_col_reg;
        len_next     = len_reg;
        use_bt       = 1'b0;
        e1_vld       = 1'b0;
        e1           = make_tok(TK_WORD, tok_row_reg, tok_col_reg, len_reg);
        e2_vld       = 1'b0;
        e2           = make_tok(bt_kind, row_cur, col_cur, LEN_BITS'(1));

        if (item.kind == ITEM_END)
        begin
            // close a pending token, then the end token
            case (mode_reg)
                MODE_WORD:
                begin
                    e1_vld = 1'b1;
                    e1.token_kind = TK_WORD;
                end
                MODE_NUMBER:
                begin
                    e1_vld = 1'b1;
                    e1.token_kind = TK_NUMBER;
                end
                MODE_STRING:
                begin
                    e1_vld = 1'b1;
                    e1.token_kind = TK_UNCLOSED;
                end
                default:
                begin
                    e1_vld = 1'b0;
                end
            endcase
            e2_vld      = 1'b1;
            e2          = make_tok(TK_END, row_cur, col_cur, '0);
            mode_next   = MODE_IDLE;
            kw_pos_next = '0;
            esc_next    = 1'b0;
            line_next   = '0;
            col_next    = '0;
            len_next    = '0;
        end
        else
        begin
            case (mode_reg)
                MODE_COMMENT:
                begin
                    if (b == CH_NEWLINE)
                    begin
                        mode_next = MODE_IDLE;
                    end
                end
                MODE_STRING:
                begin
                    if (b == CH_NEWLINE)
                    begin
                        e1_vld = 1'b1;
                        e1.token_kind = TK_UNCLOSED;
                        mode_next = MODE_IDLE;
                    end
                    else if (!esc_reg && (b == CH_QUOTE))
                    begin
                        e1_vld = 1'b1;
                        e1.token_kind = TK_STRING;
                        mode_next = MODE_IDLE;
                    end
                    else
                    begin
                        len_next = len_inc;
                        esc_next = !esc_reg && (b == CH_BACKSLASH);
                    end
                end
                MODE_WORD:
                begin
                    if (kw_match)
                    begin
                        len_next = len_inc;
                        if (kw_pos_reg + KW_POS_BITS'(1) == kw_len(kw_id_reg))
                        begin
                            e1_vld = 1'b1;
                            e1 = make_tok(TK_KW_BASE + {2'b00, kw_id_reg},
                                          tok_row_reg, tok_col_reg, len_inc);
                            mode_next   = MODE_IDLE;
                            kw_pos_next = '0;
                        end
                        else
                        begin
                            kw_pos_next = kw_pos_reg + KW_POS_BITS'(1);
                        end
                    end
                    else
                    begin
                        kw_pos_next = '0;
                        if (is_alpha(b) || is_digit(b) || (b == CH_UNDERSCORE))
                        begin
                            len_next = len_inc;
                        end
                        else
                        begin
                            e1_vld = 1'b1;
                            e1.token_kind = TK_WORD;
                            use_bt = 1'b1;
                        end
                    end
                end
                MODE_NUMBER:
                begin
                    if (is_alpha(b) || is_digit(b))
                    begin
                        len_next = len_inc;
                    end
                    else
                    begin
                        e1_vld = 1'b1;
                        e1.token_kind = TK_NUMBER;
                        use_bt = 1'b1;
                    end
                end
                default:
                begin
                    use_bt = 1'b1;
                end
            endcase

            // start a new token at this byte
            if (use_bt)
            begin
                tok_row_next = row_cur;
                tok_col_next = col_cur;
                mode_next    = bt_mode;
                kw_id_next   = bt_kw_id;
                kw_pos_next  = bt_kw_pos;
                len_next     = bt_len;
                esc_next     = 1'b0;
                e2_vld       = bt_emit;
            end

            // position of the next byte
            if (b == CH_NEWLINE)
            begin
                line_next = sat_pos(line_reg);
                col_next  = '0;
            end
            else
            begin
                col_next = sat_pos(col_reg);
            end
        end
    end

    // pack emitted tokens in order, mark the last one
    always_comb
    begin
        pair.first  = e1_vld ? e1 : e2;
        pair.second = e2;
        pair.cnt    = {1'b0, e1_vld} + {1'b0, e2_vld};
        if (e1_vld && e2_vld)
        begin
            pair.first.last_of_run  = 1'b0;
            pair.second.last_of_run = 1'b1;
        end
        else
        begin
            pair.first.last_of_run  = 1'b1;
            pair.second.last_of_run = 1'b0;
        end
    end

    // lexer state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= MODE_IDLE;
            kw_id_reg   <= KW_LET;
            kw_pos_reg  <= '0;
            esc_reg     <= 1'b0;
            line_reg    <= '0;
            col_reg     <= '0;
            tok_row_reg <= '0;
            tok_col_reg <= '0;
            len_reg     <= '0;
        end
        else if (step)
        begin
            mode_reg    <= mode_next;
            kw_id_reg   <= kw_id_next;
            kw_pos_reg  <= kw_pos_next;
            esc_reg     <= esc_next;
            line_reg    <= line_next;
            col_reg     <= col_next;
            tok_row_reg <= tok_row_next;
            tok_col_reg <= tok_col_next;
            len_reg     <= len_next;
        end
    end

    // comment byte register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            comment_char_reg <= COMMENT_RESET;
        end
        else if (cfg_we)
        begin
            comment_char_reg <= cfg_data;
        end
    end

endmodule
`default_nettype wire

// ----- hw/rtl/stt_tok_fifo.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// stt_tok_fifo: four-entry token queue
// Takes up to two token words per cycle from the lexer core and hands out
// one per cycle on the token channel while it is popped.
// ----------------------------------------------------------------------------
module stt_tok_fifo (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  wire stt_pkg::tok_pair_t pair,
    input  wire logic               pop,
    output stt_pkg::tok_item_t      head,
    output logic                    not_empty,
    output logic                    room_two
);
    import stt_pkg::*;

    localparam int DEPTH    = 4;
    localparam int PTR_BITS = $clog2(DEPTH);
    localparam int CNT_BITS = PTR_BITS + 1;

    tok_item_t              mem_reg [DEPTH];
    logic [PTR_BITS-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CNT_BITS-1:0]    count_reg, count_next;
    logic [CNT_BITS-1:0]    push_n;
    logic [PTR_BITS-1:0]    wr_ptr_plus;

    assign push_n      = push ? CNT_BITS'(pair.cnt) : '0;
    assign wr_ptr_plus = wr_ptr_reg + PTR_BITS'(1);
    assign wr_ptr_next = wr_ptr_reg + push_n[PTR_BITS-1:0];
    assign rd_ptr_next = rd_ptr_reg + PTR_BITS'(pop);
    assign count_next  = count_reg + push_n - CNT_BITS'(pop);

    assign head      = mem_reg[rd_ptr_reg];
    assign not_empty = (count_reg != '0);
    assign room_two  = (count_reg <= CNT_BITS'(DEPTH - 2));

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push_n != '0)
        begin
            mem_reg[wr_ptr_reg] <= pair.first;
        end
        if (push_n == CNT_BITS'(2))
        begin
            mem_reg[wr_ptr_plus] <= pair.second;
        end
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule
`default_nettype wire

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench for the source text tokenizer
// Feeds directed and random source text into the lexer. A behavioral lexer
// steps on every accepted source word and queues the token words it expects.
// Each token word that leaves the block is compared field by field with the
// oldest one queued. Both channels idle and stall at random. The comment byte
// is changed between phases.
// ----------------------------------------------------------------------------
module tb_top;
    import stt_pkg::*;

    localparam int IDLE_LIMIT   = 2000;
    localparam int RANDOM_ITEMS = 40;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       src_valid = 1'b0;
    logic       src_stall;
    src_item_t  src_word  = '0;
    logic       tok_valid;
    logic       tok_stall = 1'b0;
    tok_item_t  tok_word;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [7:0] cfg_data  = 8'h00;

    // idling percentages per phase: none, sender, receiver, both
    int idle_src[4] = '{0, 45, 0, 8};
    int idle_tok[4] = '{0, 0, 45, 8};
    int src_idle_pct  = 0;
    int tok_stall_pct = 0;

    int mismatches  = 0;
    int idle_cycles = 0;
    int items_sent  = 0;
    int punct_next  = 0;

    // lexer state tracked alongside the block
    lex_mode_t           lx_mode  = MODE_IDLE;
    logic                kw_on    = 1'b0;
    int                  kw_id    = 0;
    int                  kw_pos   = 0;
    logic                str_esc  = 1'b0;
    logic [POS_BITS-1:0] line_cnt = '0;
    logic [POS_BITS-1:0] col_cnt  = '0;
    logic [POS_BITS-1:0] tok_row  = '0;
    logic [POS_BITS-1:0] tok_col  = '0;
    logic [LEN_BITS-1:0] tok_len  = '0;
    logic [7:0]          cmt_char = COMMENT_RESET;

    // token words still owed by the block, oldest first
    tok_item_t pending_tokens[$];

    string kw_names[5] = '{"let", "proc", "if", "while", "return"};
    string punct_set   = "(){}[];:^=+-*/,<";
    string odd_set     = "!$%&'.>?@|~";

    source_text_tokenizer u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (src_valid),
        .src_stall (src_stall),
        .src_word  (src_word),
        .tok_valid (tok_valid),
        .tok_stall (tok_stall),
        .tok_word  (tok_word),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // behavioral lexer
    // ------------------------------------------------------------------------

    function automatic logic [POS_BITS-1:0] pos_next(input logic [POS_BITS-1:0] v);
        if (&v)
            return v;
        return v + 1'b1;
    endfunction

    function automatic logic [LEN_BITS-1:0] len_next(input logic [LEN_BITS-1:0] v);
        if (&v)
            return v;
        return v + 1'b1;
    endfunction

    function automatic logic is_blank(input logic [7:0] b);
        return (b == 8'h20) || (b > 8'h08 && b < 8'h0E);
    endfunction

    function automatic logic is_letter(input logic [7:0] b);
        return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
    endfunction

    function automatic logic is_numeral(input logic [7:0] b);
        return b >= "0" && b <= "9";
    endfunction

    function automatic void push_token(input logic [KIND_BITS-1:0] kind,
                                       input logic [POS_BITS-1:0]  row,
                                       input logic [POS_BITS-1:0]  col,
                                       input logic [LEN_BITS-1:0]  len);
        tok_item_t t;
        t.token_kind   = kind;
        t.start_row    = row;
        t.start_col    = col;
        t.token_length = len;
        t.last_of_run  = 1'b0;
        pending_tokens.push_back(t);
    endfunction

    // byte at a token boundary
    function automatic void open_token(input logic [7:0]         b,
                                       input logic [POS_BITS-1:0] row,
                                       input logic [POS_BITS-1:0] col);
        int i;
        tok_row = row;
        tok_col = col;
        lx_mode = MODE_IDLE;
        kw_on   = 1'b0;
        if (is_blank(b))
            return;
        if (b == cmt_char)
        begin
            lx_mode = MODE_COMMENT;
            return;
        end
        for (i = 0; i < 16; i++)
        begin
            if (punct_set[i] == b)
            begin
                push_token(TK_PUNCT_BASE + KIND_BITS'(i), row, col, LEN_BITS'(1));
                return;
            end
        end
        if (b == CH_QUOTE)
        begin
            lx_mode = MODE_STRING;
            str_esc = 1'b0;
            tok_len = '0;
            return;
        end
        if (is_letter(b) || b == CH_UNDERSCORE)
        begin
            lx_mode = MODE_WORD;
            tok_len = LEN_BITS'(1);
            // first letter may open a keyword candidate
            for (i = 0; i < 5; i++)
            begin
                if (kw_names[i][0] == b)
                begin
                    kw_on  = 1'b1;
                    kw_id  = i;
                    kw_pos = 1;
                end
            end
            return;
        end
        if (is_numeral(b))
        begin
            lx_mode = MODE_NUMBER;
            tok_len = LEN_BITS'(1);
            return;
        end
        push_token(TK_UNKNOWN, row, col, LEN_BITS'(1));
    endfunction

    // advance the lexer by one accepted source word
    function automatic void lex_source_word(input src_item_t w);
        int                  base;
        logic [7:0]          b;
        logic [POS_BITS-1:0] row;
        logic [POS_BITS-1:0] col;
        tok_item_t           last;
        base = pending_tokens.size();
        b    = w.text_byte;
        row  = pos_next(line_cnt);
        col  = pos_next(col_cnt);
        if (w.kind == ITEM_END)
        begin
            // close a pending token, then the end token at the next position
            case (lx_mode)
                MODE_WORD:   push_token(TK_WORD, tok_row, tok_col, tok_len);
                MODE_NUMBER: push_token(TK_NUMBER, tok_row, tok_col, tok_len);
                MODE_STRING: push_token(TK_UNCLOSED, tok_row, tok_col, tok_len);
                default:     ;
            endcase
            push_token(TK_END, row, col, '0);
            lx_mode  = MODE_IDLE;
            kw_on    = 1'b0;
            str_esc  = 1'b0;
            line_cnt = '0;
            col_cnt  = '0;
            tok_len  = '0;
        end
        else
        begin
            case (lx_mode)
                MODE_COMMENT:
                begin
                    if (b == CH_NEWLINE)
                        lx_mode = MODE_IDLE;
                end
                MODE_STRING:
                begin
                    // newline cuts the string even after a backslash
                    if (b == CH_NEWLINE)
                    begin
                        push_token(TK_UNCLOSED, tok_row, tok_col, tok_len);
                        lx_mode = MODE_IDLE;
                    end
                    else if (!str_esc && b == CH_QUOTE)
                    begin
                        push_token(TK_STRING, tok_row, tok_col, tok_len);
                        lx_mode = MODE_IDLE;
                    end
                    else
                    begin
                        tok_len = len_next(tok_len);
                        str_esc = !str_esc && b == CH_BACKSLASH;
                    end
                end
                MODE_WORD:
                begin
                    if (kw_on && kw_names[kw_id][kw_pos] == b)
                    begin
                        tok_len = len_next(tok_len);
                        if (kw_pos + 1 == kw_names[kw_id].len())
                        begin
                            push_token(TK_KW_BASE + KIND_BITS'(kw_id), tok_row, tok_col,
                                       tok_len);
                            lx_mode = MODE_IDLE;
                            kw_on   = 1'b0;
                        end
                        else
                            kw_pos++;
                    end
                    else
                    begin
                        // failed candidate stays a plain word
                        kw_on = 1'b0;
                        if (is_letter(b) || is_numeral(b) || b == CH_UNDERSCORE)
                            tok_len = len_next(tok_len);
                        else
                        begin
                            push_token(TK_WORD, tok_row, tok_col, tok_len);
                            open_token(b, row, col);
                        end
                    end
                end
                MODE_NUMBER:
                begin
                    if (is_letter(b) || is_numeral(b))
                        tok_len = len_next(tok_len);
                    else
                    begin
                        push_token(TK_NUMBER, tok_row, tok_col, tok_len);
                        open_token(b, row, col);
                    end
                end
                default: open_token(b, row, col);
            endcase
            if (b == CH_NEWLINE)
            begin
                line_cnt = pos_next(line_cnt);
                col_cnt  = '0;
            end
            else
                col_cnt = pos_next(col_cnt);
        end
        // flag the last token word of this source word
        if (pending_tokens.size() > base)
        begin
            last             = pending_tokens.pop_back();
            last.last_of_run = 1'b1;
            pending_tokens.push_back(last);
        end
    endfunction

    // ------------------------------------------------------------------------
    // token checking, receiver stalls and watchdog
    // ------------------------------------------------------------------------

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            mismatches++;
        end
    endfunction

    // compare each accepted token word with the oldest one owed
    always @(posedge clk)
    begin : check_tokens
        tok_item_t want;
        if (rst_n && tok_valid && !tok_stall)
        begin
            if (pending_tokens.size() == 0)
            begin
                $error("token word with none expected: kind %0d row %0d col %0d",
                       tok_word.token_kind, tok_word.start_row, tok_word.start_col);
                mismatches++;
            end
            else
            begin
                want = pending_tokens.pop_front();
                check_field("token_kind", 32'(want.token_kind), 32'(tok_word.token_kind));
                check_field("start_row", 32'(want.start_row), 32'(tok_word.start_row));
                check_field("start_col", 32'(want.start_col), 32'(tok_word.start_col));
                check_field("token_length", 32'(want.token_length),
                            32'(tok_word.token_length));
                check_field("last_of_run", 32'(want.last_of_run), 32'(tok_word.last_of_run));
            end
        end
    end

    // random receiver stall
    always @(posedge clk)
        tok_stall <= ($urandom_range(0, 99) < tok_stall_pct);

    // end the run if no word moves on either channel for too long
    always @(posedge clk)
    begin
        if ((src_valid && !src_stall) || (tok_valid && !tok_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------

    task automatic set_idling(input int mode);
        src_idle_pct  = idle_src[mode];
        tok_stall_pct = idle_tok[mode];
    endtask

    // one source word, with a random gap before it
    task automatic send_item(input src_item_t w);
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            src_valid <= 1'b0;
            @(posedge clk);
        end
        src_valid <= 1'b1;
        src_word  <= w;
        @(posedge clk);
        while (src_stall)
            @(posedge clk);
        items_sent++;
        lex_source_word(w);
    endtask

    task automatic send_byte(input logic [7:0] b);
        send_item({ITEM_BYTE, b});
    endtask

    task automatic send_end();
        send_item({ITEM_END, 8'($urandom_range(0, 255))});
    endtask

    task automatic send_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
            send_byte(s[i]);
    endtask

    // hold the sender until every owed token word is out and the lexer is quiet
    task automatic wait_drained();
        src_valid <= 1'b0;
        while (pending_tokens.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_comment_char(input logic [7:0] v);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        cmt_char = v;
    endtask

    // digits 0..9, lower 10..35, upper 36..61, underscore 62
    function automatic logic [7:0] rand_word_char(input int lo, input int hi);
        int r;
        r = $urandom_range(lo, hi);
        if (r < 10)
            return 8'("0" + r);
        if (r < 36)
            return 8'("a" + r - 10);
        if (r < 62)
            return 8'("A" + r - 36);
        return CH_UNDERSCORE;
    endfunction

    // one random piece of source text, mostly well formed
    task automatic send_fragment();
        int         pick;
        int         n;
        int         cut;
        int         i;
        int         r;
        logic [7:0] b;
        pick = $urandom_range(0, 99);
        if (pick < 15)
        begin
            // keyword in full or cut short, sometimes running on
            n   = $urandom_range(0, 4);
            cut = $urandom_range(1, kw_names[n].len());
            for (i = 0; i < cut; i++)
                send_byte(kw_names[n][i]);
            if ($urandom_range(0, 2) == 0)
                send_byte(rand_word_char(0, 62));
        end
        else if (pick < 27)
        begin
            send_byte(rand_word_char(10, 62));
            n = $urandom_range(0, 6);
            for (i = 0; i < n; i++)
                send_byte(rand_word_char(0, 62));
        end
        else if (pick < 35)
        begin
            send_byte(rand_word_char(0, 9));
            n = $urandom_range(0, 5);
            for (i = 0; i < n; i++)
                send_byte(rand_word_char(0, 61));
        end
        else if (pick < 50)
        begin
            // punctuators in turn so every one shows up
            send_byte(punct_set[punct_next]);
            punct_next = (punct_next + 1) % 16;
        end
        else if (pick < 58)
        begin
            n = $urandom_range(1, 3);
            for (i = 0; i < n; i++)
            begin
                b = 8'($urandom_range(9, 14));
                send_byte((b == 8'd14) ? 8'h20 : b);
            end
        end
        else if (pick < 70)
        begin
            // string with escapes, closed, cut by a newline or left open
            send_byte(CH_QUOTE);
            n = $urandom_range(0, 6);
            for (i = 0; i < n; i++)
            begin
                if ($urandom_range(0, 5) == 0)
                begin
                    send_byte(CH_BACKSLASH);
                    send_byte(($urandom_range(0, 1) == 0) ? CH_QUOTE : CH_BACKSLASH);
                end
                else
                begin
                    b = 8'($urandom_range(32, 126));
                    send_byte((b == CH_QUOTE) ? 8'h78 : b);
                end
            end
            r = $urandom_range(0, 9);
            if (r < 6)
                send_byte(CH_QUOTE);
            else if (r < 8)
                send_byte(CH_NEWLINE);
            else if (r == 8)
            begin
                send_byte(CH_BACKSLASH);
                send_byte(CH_NEWLINE);
            end
        end
        else if (pick < 77)
        begin
            send_byte(cmt_char);
            n = $urandom_range(0, 5);
            for (i = 0; i < n; i++)
            begin
                b = 8'($urandom_range(0, 255));
                send_byte((b == CH_NEWLINE) ? 8'h20 : b);
            end
            if ($urandom_range(0, 4) != 0)
                send_byte(CH_NEWLINE);
        end
        else if (pick < 84)
        begin
            // bytes in no token class
            r = $urandom_range(0, 3);
            if (r == 0)
                send_byte(($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 8))
                                                      : 8'($urandom_range(14, 31)));
            else if (r == 1)
                send_byte(odd_set[$urandom_range(0, odd_set.len() - 1)]);
            else if (r == 2)
                send_byte(8'($urandom_range(128, 255)));
            else
                send_byte(8'h7F);
        end
        else if (pick < 93)
        begin
            n = $urandom_range(1, 3);
            for (i = 0; i < n; i++)
                send_byte(8'($urandom_range(0, 255)));
        end
        else
            send_end();
        // optional separator, otherwise tokens touch
        if ($urandom_range(0, 9) < 4)
            send_byte(($urandom_range(0, 2) == 0) ? CH_NEWLINE : 8'h20);
    endtask

    task automatic run_random_text(input int count);
        int first;
        first = items_sent;
        while (items_sent - first < count)
            send_fragment();
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // keyword prefix, two tokens from one byte, escapes, unclosed string,
    // comment, number into word, odd bytes, end closing a word
    task automatic test_basic_lexing();
        set_idling(0);
        send_text("letter(if\"a\\\"b\\\n");
        send_text("#x\n9z_ ");
        send_byte(8'h00);
        send_byte(8'hFF);
        send_text("whil");
        send_end();
    endtask

    // comment byte at its extremes and on bytes that compete with other tokens
    task automatic test_comment_char_settings();
        logic [7:0] chars[8] = '{8'h00, 8'hFF, 8'h6C, CH_QUOTE, 8'h28, 8'h37, CH_NEWLINE,
                                 COMMENT_RESET};
        int p;
        for (p = 0; p < 8; p++)
        begin
            set_idling(p % 4);
            write_comment_char(chars[p]);
            run_random_text(RANDOM_ITEMS);
        end
    endtask

    // sender holds off until every token word is out, then resumes
    task automatic test_drained_restart();
        set_idling(1);
        run_random_text(20);
        wait_drained();
        run_random_text(20);
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        test_basic_lexing();
        test_comment_char_settings();
        test_drained_restart();
        wait_drained();
        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ----- sim.f -----
hw/rtl/stt_pkg.sv
hw/rtl/stt_lex_core.sv
hw/rtl/stt_tok_fifo.sv
hw/rtl/source_text_tokenizer.sv
tb/tb_top.sv
